[hdl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

  // field widths
  localparam int HUE_W  = 15;
  localparam int CHAN_W = 8;

  // hue sector geometry: 60 degrees in 1/64 degree units
  localparam int SECTOR_SPAN = 3840;
  localparam int FULL_CODE   = 255;
  localparam int FRAC_W      = 12;
  localparam int SEC_W       = 4;
  localparam int SECTOR_LAST = (2 ** HUE_W - 1) / SECTOR_SPAN;

  // scaling: level = floor(val * (DEN - sat * x) / DEN), DEN = 255 * 3840
  localparam int SCALE_DEN   = FULL_CODE * SECTOR_SPAN;
  localparam int COEF_W      = 20;
  localparam int NUM_W       = COEF_W + CHAN_W;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'((64'd1 << RECIP_SHIFT) / SCALE_DEN);

  // sector codes
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 4'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 4'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 4'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 4'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 4'd4;

  // per-stage advance enables of one scaling lane
  typedef struct packed {
    logic coef;
    logic prod;
    logic est;
    logic fix;
  } lane_en_t;

  // first hue code of a sector
  function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sec);
    sector_base = HUE_W'(sec) * HUE_W'(SECTOR_SPAN);
  endfunction

endpackage

[hdl/hsvrgb_sector.sv]
module hsvrgb_sector (
  input  logic                             clk,
  input  logic                             en,
  input  logic [hsvrgb_pkg::HUE_W-1:0]     hue,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]    sat_in,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]    val_in,
  output logic [hsvrgb_pkg::SEC_W-1:0]     sector,
  output logic [hsvrgb_pkg::FRAC_W-1:0]    rem,
  output logic [hsvrgb_pkg::FRAC_W-1:0]    rem_inv,
  output logic [hsvrgb_pkg::CHAN_W-1:0]    sat_out,
  output logic [hsvrgb_pkg::CHAN_W-1:0]    val_out
);
  import hsvrgb_pkg::*;

  logic [SEC_W-1:0]  sector_next;
  logic [HUE_W-1:0]  rem_full;
  logic [FRAC_W-1:0] rem_next;

  // sector from parallel threshold compares, remainder by subtracting its base
  always_comb begin
    sector_next = '0;
    for (int k = 1; k <= SECTOR_LAST; k++) begin
      if (hue >= HUE_W'(k * SECTOR_SPAN)) begin
        sector_next = SEC_W'(k);
      end
    end
    rem_full = hue - sector_base(sector_next);
    rem_next = rem_full[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector  <= sector_next;
      rem     <= rem_next;
      rem_inv <= FRAC_W'(SECTOR_SPAN) - rem_next;
      sat_out <= sat_in;
      val_out <= val_in;
    end
  end

endmodule

[hdl/hsvrgb_lane.sv]
module hsvrgb_lane (
  input  logic                           clk,
  input  hsvrgb_pkg::lane_en_t           en,
  input  logic [hsvrgb_pkg::FRAC_W-1:0]  frac,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]  sat,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]  val,
  output logic [hsvrgb_pkg::CHAN_W-1:0]  level
);
  import hsvrgb_pkg::*;

  localparam int EST_FULL_W = NUM_W + RECIP_W;

  logic [COEF_W-1:0]     coef;
  logic [CHAN_W-1:0]     val_c;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      num_e;
  logic [CHAN_W-1:0]     est;
  logic [EST_FULL_W-1:0] est_full;
  logic [NUM_W-1:0]      resid;

  // coefficient: DEN - sat * x, never negative since x <= 3840
  always_ff @(posedge clk) begin
    if (en.coef) begin
      coef  <= COEF_W'(SCALE_DEN) - COEF_W'(sat) * COEF_W'(frac);
      val_c <= val;
    end
  end

  // numerator
  always_ff @(posedge clk) begin
    if (en.prod) begin
      num <= NUM_W'(val_c) * NUM_W'(coef);
    end
  end

  // quotient estimate by reciprocal, low by at most one
  assign est_full = EST_FULL_W'(num) * EST_FULL_W'(RECIP_K);

  always_ff @(posedge clk) begin
    if (en.est) begin
      est   <= est_full[RECIP_SHIFT +: CHAN_W];
      num_e <= num;
    end
  end

  // correction step on the remainder
  assign resid = num_e - NUM_W'(est) * NUM_W'(SCALE_DEN);

  always_ff @(posedge clk) begin
    if (en.fix) begin
      level <= est + CHAN_W'(resid >= NUM_W'(SCALE_DEN));
    end
  end

endmodule

[hdl/hsv_to_rgb_convert.sv]
// HSV to RGB converter. Hue comes in 1/64 degree units (60 degree sectors of 3840
// codes), saturation and brightness as 8-bit fractions of 255; the block returns
// 8-bit red, green and blue with each of p, q and t truncated exactly. It takes one
// beat per clock when nothing stalls; each result passes in order through sector
// split, coefficient multiply, numerator multiply, reciprocal estimate, remainder
// correction and channel select. There are six register stages, each with its own
// advance enable that the three scaling lanes share; a stall on the output holds
// each full stage whose later stages are all full, and the input stalls only once
// every stage is occupied. Zero saturation comes out grey; hue codes past 19199 use
// the magenta-to-red channel order.
module hsv_to_rgb_convert (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsvrgb_pkg::HUE_W-1:0]    hue,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]   saturation,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]   brightness,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   red,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   green,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   blue
);
  import hsvrgb_pkg::*;

  localparam int STAGES   = 6;
  localparam int ST_SEC   = 0;
  localparam int ST_COEF  = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_EST   = 3;
  localparam int ST_FIX   = 4;
  localparam int ST_OUT   = 5;

  logic [STAGES-1:0] valid_pipe;
  logic [STAGES-1:0] en;
  lane_en_t          lane_en;

  logic [SEC_W-1:0]  sector0;
  logic [FRAC_W-1:0] rem0;
  logic [FRAC_W-1:0] rem_inv0;
  logic [CHAN_W-1:0] sat0;
  logic [CHAN_W-1:0] val0;

  logic [SEC_W-1:0]  sec_pipe [ST_COEF:ST_FIX];
  logic [CHAN_W-1:0] val_pipe [ST_COEF:ST_FIX];

  logic [CHAN_W-1:0] p_lvl;
  logic [CHAN_W-1:0] q_lvl;
  logic [CHAN_W-1:0] t_lvl;
  logic [CHAN_W-1:0] m_lvl;
  logic [CHAN_W-1:0] red_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] blue_next;

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    en[ST_OUT] = !valid_pipe[ST_OUT] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_pipe[i] || en[i+1];
    end
  end

  assign in_stall  = !en[ST_SEC];
  assign out_valid = valid_pipe[ST_OUT];
  assign lane_en   = '{coef: en[ST_COEF], prod: en[ST_PROD], est: en[ST_EST],
                       fix: en[ST_FIX]};

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      if (en[ST_SEC]) begin
        valid_pipe[ST_SEC] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid_pipe[i] <= valid_pipe[i-1];
        end
      end
    end
  end

  hsvrgb_sector u_sector (
    .clk     (clk),
    .en      (en[ST_SEC]),
    .hue     (hue),
    .sat_in  (saturation),
    .val_in  (brightness),
    .sector  (sector0),
    .rem     (rem0),
    .rem_inv (rem_inv0),
    .sat_out (sat0),
    .val_out (val0)
  );

  // p, q and t lanes: x is the full span, the remainder and its complement
  hsvrgb_lane u_lane_p (
    .clk   (clk),
    .en    (lane_en),
    .frac  (FRAC_W'(SECTOR_SPAN)),
    .sat   (sat0),
    .val   (val0),
    .level (p_lvl)
  );

  hsvrgb_lane u_lane_q (
    .clk   (clk),
    .en    (lane_en),
    .frac  (rem0),
    .sat   (sat0),
    .val   (val0),
    .level (q_lvl)
  );

  hsvrgb_lane u_lane_t (
    .clk   (clk),
    .en    (lane_en),
    .frac  (rem_inv0),
    .sat   (sat0),
    .val   (val0),
    .level (t_lvl)
  );

  // sector and brightness ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en[ST_COEF]) begin
      sec_pipe[ST_COEF] <= sector0;
      val_pipe[ST_COEF] <= val0;
    end
    for (int i = ST_PROD; i <= ST_FIX; i++) begin
      if (en[i]) begin
        sec_pipe[i] <= sec_pipe[i-1];
        val_pipe[i] <= val_pipe[i-1];
      end
    end
  end

  assign m_lvl = val_pipe[ST_FIX];

  // channel order by sector
  always_comb begin
    case (sec_pipe[ST_FIX])
      SEC_RED_YEL: begin
        red_next = m_lvl; green_next = t_lvl; blue_next = p_lvl;
      end
      SEC_YEL_GRN: begin
        red_next = q_lvl; green_next = m_lvl; blue_next = p_lvl;
      end
      SEC_GRN_CYN: begin
        red_next = p_lvl; green_next = m_lvl; blue_next = t_lvl;
      end
      SEC_CYN_BLU: begin
        red_next = p_lvl; green_next = q_lvl; blue_next = m_lvl;
      end
      SEC_BLU_MAG: begin
        red_next = t_lvl; green_next = p_lvl; blue_next = m_lvl;
      end
      default: begin
        red_next = m_lvl; green_next = p_lvl; blue_next = q_lvl;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

`ifndef SYNTHESIS
  // no scaled level may exceed the brightness
  assert property (@(posedge clk) disable iff (rst)
    valid_pipe[ST_FIX] |-> (p_lvl <= m_lvl && q_lvl <= m_lvl && t_lvl <= m_lvl))
    else $error("scaled level above brightness");

  // p carries the largest reduction, so it is never above q or t
  assert property (@(posedge clk) disable iff (rst)
    valid_pipe[ST_FIX] |-> (p_lvl <= q_lvl && p_lvl <= t_lvl))
    else $error("p level above q or t");

  // input back-pressure only when every stage holds a beat
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid_pipe))
    else $error("input stalled with a free stage");
`endif

endmodule
